// ----- sv/lpft_pkg.sv -----
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared widths, register indexes, reset values and payload types of the
// lidar point filter and rigid transform.
// ----------------------------------------------------------------------------
`default_nettype none

package lpft_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int COEF_FRAC_BITS = 14;

  localparam int COEF_W     = 16;
  localparam int OFF_W      = 16;
  localparam int OUT_W      = 21;
  localparam int BYTE_W     = 8;
  localparam int ROW_W      = 64;
  localparam int RANGE_W    = 40;
  localparam int CROP_W     = 32;
  localparam int CROP_HALF  = 16;
  localparam int CTL_W      = 18;
  localparam int NUM_AXES   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - COEF_FRAC_BITS;
  localparam int T_PRE  = (SH_W > OFF_W) ? SH_W : OFF_W;
  localparam int T_W    = ((T_PRE > OUT_W) ? T_PRE : OUT_W) + 1;
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int RS_W   = SQ_W + 2;
  localparam int CMP_W  = (RS_W > RANGE_W) ? RS_W : RANGE_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_AW + 1;

  // control register fields
  localparam int CTL_LINE_LSB  = 0;
  localparam int CTL_DECIM_LSB = 8;
  localparam int CTL_TAG_EN    = 16;
  localparam int CTL_CROP_EN   = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_R2  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_R2  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = CFG_IDX_W'(7);

  // tag spatial class
  localparam logic [BYTE_W-1:0] TAG_CLASS_MASK = 8'h30;
  localparam logic [BYTE_W-1:0] TAG_CLASS_A    = 8'h00;
  localparam logic [BYTE_W-1:0] TAG_CLASS_B    = 8'h10;

  typedef struct packed {
    logic [NUM_AXES-1:0][ROW_W-1:0] row;
    logic [RANGE_W-1:0]             min_r2;
    logic [RANGE_W-1:0]             max_r2;
    logic [CROP_W-1:0]              crop_x;
    logic [CROP_W-1:0]              crop_y;
    logic [CTL_W-1:0]               control;
  } cfg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
    logic [BYTE_W-1:0]      refl;
  } point_t;

  localparam cfg_t CFG_RESET = '{
    row:     '{64'h0000_0000_4000_0384, 64'h0000_4000_0000_0000,
               64'h4000_0000_0000_00C8},
    min_r2:  40'd250000,
    max_r2:  40'd10000000000,
    crop_x:  32'hFD12_02EE,
    crop_y:  32'hFE0C_01F4,
    control: 18'h1_0104
  };

endpackage

`default_nettype wire

// ----- sv/lpft_ifs.sv -----
// ----------------------------------------------------------------------------
// lpft_ifs
// Valid/ready channels of the point filter: input points, result points and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpft_in_if;
  import lpft_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   frame_start;
  logic [COORD_WIDTH-1:0] x_mm;
  logic [COORD_WIDTH-1:0] y_mm;
  logic [COORD_WIDTH-1:0] z_mm;
  logic [BYTE_W-1:0]      reflectivity;
  logic [BYTE_W-1:0]      tag;
  logic [BYTE_W-1:0]      line;
  modport source (output valid, frame_start, x_mm, y_mm, z_mm, reflectivity, tag, line,
                  input ready);
  modport sink (input valid, frame_start, x_mm, y_mm, z_mm, reflectivity, tag, line,
                output ready);
endinterface

interface lpft_out_if;
  import lpft_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUT_W-1:0]  x_out;
  logic [OUT_W-1:0]  y_out;
  logic [OUT_W-1:0]  z_out;
  logic [BYTE_W-1:0] intensity;
  modport source (output valid, x_out, y_out, z_out, intensity, input ready);
  modport sink (input valid, x_out, y_out, z_out, intensity, output ready);
endinterface

interface lpft_cfg_if;
  import lpft_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ----- sv/lpft_front.sv -----
// ----------------------------------------------------------------------------
// lpft_front
// Accepts points, runs decimation, line and tag checks, squares the range
// over two stages and pushes kept points into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  lpft_in_if.sink             in_ch,
  input  wire lpft_pkg::cfg_t cfg,
  input  wire logic           q_full,
  output logic                q_push,
  output lpft_pkg::point_t    q_data
);
  import lpft_pkg::*;

  logic [BYTE_W-1:0]                       dcnt_r;
  logic [BYTE_W-1:0]                       dcnt_nxt;
  logic [BYTE_W-1:0]                       dcnt_cur;
  logic [BYTE_W:0]                         dcnt_inc;
  logic [BYTE_W-1:0]                       decim;
  logic [BYTE_W-1:0]                       line_lim;
  logic [BYTE_W-1:0]                       tag_cls;
  logic                                    pre_keep;
  logic                                    accept;
  logic                                    adv;
  logic                                    keep_all;
  point_t                                  in_pt;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]    crd;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]    abs_in;
  logic [NUM_AXES-1:0][SQ_W-1:0]           sq;
  logic [RS_W-1:0]                         r2;

  logic                                    f1_v_r;
  logic                                    f1_keep_r;
  point_t                                  f1_pt_r;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]    f1_abs_r;
  logic                                    f2_v_r;
  logic                                    f2_keep_r;
  point_t                                  f2_pt_r;
  logic [NUM_AXES-1:0][SQ_W-1:0]           f2_sq_r;

  always_comb begin
    in_pt.x    = in_ch.x_mm;
    in_pt.y    = in_ch.y_mm;
    in_pt.z    = in_ch.z_mm;
    in_pt.refl = in_ch.reflectivity;
    crd[0]     = in_ch.x_mm;
    crd[1]     = in_ch.y_mm;
    crd[2]     = in_ch.z_mm;
    for (int i = 0; i < NUM_AXES; i++) begin
      abs_in[i] = crd[i][COORD_WIDTH-1] ? (~crd[i] + 1'b1) : crd[i];
    end

    decim    = cfg.control[CTL_DECIM_LSB +: BYTE_W];
    if (decim == '0) begin
      decim = BYTE_W'(1);
    end
    dcnt_cur = in_ch.frame_start ? '0 : dcnt_r;
    dcnt_inc = {1'b0, dcnt_cur} + 1'b1;
    dcnt_nxt = (dcnt_inc >= {1'b0, decim}) ? '0 : dcnt_inc[BYTE_W-1:0];

    line_lim = cfg.control[CTL_LINE_LSB +: BYTE_W];
    tag_cls  = in_ch.tag & TAG_CLASS_MASK;
    pre_keep = (dcnt_cur == '0)
            && !((line_lim != '0) && (in_ch.line >= line_lim))
            && (!cfg.control[CTL_TAG_EN] || (tag_cls == TAG_CLASS_A)
                || (tag_cls == TAG_CLASS_B));

    for (int i = 0; i < NUM_AXES; i++) begin
      sq[i] = SQ_W'(f1_abs_r[i]) * SQ_W'(f1_abs_r[i]);
    end

    r2       = RS_W'(f2_sq_r[0]) + RS_W'(f2_sq_r[1]) + RS_W'(f2_sq_r[2]);
    keep_all = f2_keep_r
            && (CMP_W'(r2) >= CMP_W'(cfg.min_r2))
            && (CMP_W'(r2) <= CMP_W'(cfg.max_r2));

    // hold the pipe only when a kept point meets a full queue
    adv    = !(f2_v_r && keep_all && q_full);
    accept = in_ch.valid && adv;
    q_push = f2_v_r && keep_all && !q_full;
    q_data = f2_pt_r;
  end

  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
      if (accept) begin
        dcnt_r <= dcnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_keep_r <= pre_keep;
      f1_pt_r   <= in_pt;
      f1_abs_r  <= abs_in;
      f2_keep_r <= f1_keep_r;
      f2_pt_r   <= f1_pt_r;
      f2_sq_r   <= sq;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lpft_fifo.sv -----
// ----------------------------------------------------------------------------
// lpft_fifo
// Short point queue between the filter front and the transform back.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lpft_pkg::point_t wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output lpft_pkg::point_t      rdata
);
  import lpft_pkg::*;

  point_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r;
  logic [Q_AW-1:0]    rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lpft_back.sv -----
// ----------------------------------------------------------------------------
// lpft_back
// Rotates queued points, rounds, adds the offset, saturates, applies the
// crop rectangle and holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpft_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lpft_pkg::cfg_t   cfg,
  input  wire logic             q_valid,
  input  wire lpft_pkg::point_t q_data,
  output logic                  q_pop,
  lpft_out_if.source            out_ch
);
  import lpft_pkg::*;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [T_W-1:0]   SAT_HI   = T_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [T_W-1:0]   SAT_LO   = ~SAT_HI;

  logic                                           badv;
  logic                                           crop_hit;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]           crd;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_W-1:0]  coef;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][PROD_W-1:0]  prod;
  logic [NUM_AXES-1:0][SUM_W-1:0]                 sum;
  logic [NUM_AXES-1:0][SH_W-1:0]                  sh;
  logic [NUM_AXES-1:0][T_W-1:0]                   tv;
  logic [NUM_AXES-1:0][OUT_W-1:0]                 sat;

  logic                                           b1_v_r;
  logic [NUM_AXES-1:0][NUM_AXES-1:0][PROD_W-1:0]  b1_prod_r;
  logic [BYTE_W-1:0]                              b1_refl_r;
  logic                                           b2_v_r;
  logic [NUM_AXES-1:0][SUM_W-1:0]                 b2_sum_r;
  logic [BYTE_W-1:0]                              b2_refl_r;
  logic                                           b3_v_r;
  logic [NUM_AXES-1:0][OUT_W-1:0]                 b3_xyz_r;
  logic [BYTE_W-1:0]                              b3_refl_r;
  logic                                           out_v_r;
  logic [NUM_AXES-1:0][OUT_W-1:0]                 out_xyz_r;
  logic [BYTE_W-1:0]                              out_refl_r;

  always_comb begin
    badv  = !out_v_r || out_ch.ready;
    q_pop = q_valid && badv;

    crd[0] = q_data.x;
    crd[1] = q_data.y;
    crd[2] = q_data.z;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        coef[a][k] = cfg.row[a][ROW_W-1-COEF_W*k -: COEF_W];
        prod[a][k] = PROD_W'($signed(coef[a][k])) * PROD_W'($signed(crd[k]));
      end
    end

    for (int a = 0; a < NUM_AXES; a++) begin
      sum[a] = SUM_W'($signed(b1_prod_r[a][0])) + SUM_W'($signed(b1_prod_r[a][1]))
             + SUM_W'($signed(b1_prod_r[a][2])) + RND_HALF;
    end

    // floor shift, offset, saturate
    for (int a = 0; a < NUM_AXES; a++) begin
      sh[a] = b2_sum_r[a][SUM_W-1:COEF_FRAC_BITS];
      tv[a] = T_W'($signed(sh[a])) + T_W'($signed(cfg.row[a][OFF_W-1:0]));
      if ($signed(tv[a]) > SAT_HI) begin
        sat[a] = SAT_HI[OUT_W-1:0];
      end else if ($signed(tv[a]) < SAT_LO) begin
        sat[a] = SAT_LO[OUT_W-1:0];
      end else begin
        sat[a] = tv[a][OUT_W-1:0];
      end
    end

    crop_hit = cfg.control[CTL_CROP_EN]
      && ($signed(b3_xyz_r[0]) >= OUT_W'($signed(cfg.crop_x[CROP_W-1:CROP_HALF])))
      && ($signed(b3_xyz_r[0]) <= OUT_W'($signed(cfg.crop_x[CROP_HALF-1:0])))
      && ($signed(b3_xyz_r[1]) >= OUT_W'($signed(cfg.crop_y[CROP_W-1:CROP_HALF])))
      && ($signed(b3_xyz_r[1]) <= OUT_W'($signed(cfg.crop_y[CROP_HALF-1:0])));
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.x_out     = out_xyz_r[0];
  assign out_ch.y_out     = out_xyz_r[1];
  assign out_ch.z_out     = out_xyz_r[2];
  assign out_ch.intensity = out_refl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (badv) begin
      b1_v_r  <= q_pop;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      out_v_r <= b3_v_r && !crop_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      b1_prod_r <= prod;
      b1_refl_r <= q_data.refl;
      b2_sum_r  <= sum;
      b2_refl_r <= b1_refl_r;
      b3_xyz_r  <= sat;
      b3_refl_r <= b2_refl_r;
      if (b3_v_r && !crop_hit) begin
        out_xyz_r  <= b3_xyz_r;
        out_refl_r <= b3_refl_r;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/lidar_point_filter_transform.sv -----
// ----------------------------------------------------------------------------
// lidar_point_filter_transform
// Lidar point filter (decimation, line, tag, range) with a fixed-point rigid
// transform, 21-bit saturation and a crop rectangle.
//
//   channel  dir  handshake    word
//   in_ch    in   valid/ready  frame_start, x_mm, y_mm, z_mm, reflectivity, tag, line
//   out_ch   out  valid/ready  x_out, y_out, z_out, intensity
//   cfg_ch   in   valid/ready  idx, data (ready always high)
//
// One point per cycle sustained while out_ch.ready stays high; accepted points pass
// through two front stages (abs, square, range compare), the queue and four
// back stages (multiply, sum, saturate, crop/output register).
// rst_n is synchronous: clears valids, the decimation count and the queue and
// reloads the register defaults. A stalled output freezes the back stages,
// then the four-word queue fills, and only then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_filter_transform (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpft_in_if.sink    in_ch,
  lpft_out_if.source out_ch,
  lpft_cfg_if.sink   cfg_ch
);
  import lpft_pkg::*;

  cfg_t   cfg_r;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  point_t q_wdata;
  point_t q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_ROW_X:   cfg_r.row[0]  <= cfg_ch.data;
        REG_ROW_Y:   cfg_r.row[1]  <= cfg_ch.data;
        REG_ROW_Z:   cfg_r.row[2]  <= cfg_ch.data;
        REG_MIN_R2:  cfg_r.min_r2  <= cfg_ch.data[RANGE_W-1:0];
        REG_MAX_R2:  cfg_r.max_r2  <= cfg_ch.data[RANGE_W-1:0];
        REG_CROP_X:  cfg_r.crop_x  <= cfg_ch.data[CROP_W-1:0];
        REG_CROP_Y:  cfg_r.crop_y  <= cfg_ch.data[CROP_W-1:0];
        REG_CONTROL: cfg_r.control <= cfg_ch.data[CTL_W-1:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  lpft_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  lpft_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  lpft_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (!q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
